[src/ntg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_pkg
// Shared widths, register indexes, reset values and FSM type of the NTT
// twiddle generator.
// ----------------------------------------------------------------------------
package ntg_pkg;

    localparam int LOG_MAX_SIZE_DEF = 10;

    localparam int DATA_W  = 16;
    localparam int LOG_W   = 4;
    localparam int LG_W    = 5;
    localparam int CFG_A_W = 2;

    localparam logic [CFG_A_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_LOG_SIZE = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_ROOT     = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_SCALE    = 2'd3;

    localparam logic [DATA_W-1:0] MODULUS_RST  = 16'd12289;
    localparam logic [LOG_W-1:0]  LOG_SIZE_RST = 4'd9;
    localparam logic [DATA_W-1:0] ROOT_RST     = 16'd1;
    localparam logic [DATA_W-1:0] SCALE_RST    = 16'd1;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_NORM      = 7'b0000010,
        ST_RED_ROOT  = 7'b0000100,
        ST_RED_SCALE = 7'b0001000,
        ST_MUL_ACC   = 7'b0010000,
        ST_MUL_SQR   = 7'b0100000,
        ST_OUT       = 7'b1000000
    } t_state;

endpackage

[src/ntt_twiddle_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_twiddle_generator
// Computes scale * root^(j*n/(2t)) mod modulus for a table index, plus the
// centered form, using one bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Index zero, an invalid index or a zero modulus go straight to the output.
// Otherwise come s <= log_size-1 normalizing shifts, the root and scale reductions
// and m square-and-multiply products (none for log_size 1, else <= 2*log_size-3).
// Each product steps through the multiplier bits, one per cycle; one item at a time.
// The result strobe is high for one cycle; the receiver cannot stall.
// Synchronous active-low reset restores the configuration defaults and idles.
module ntt_twiddle_generator #(
    parameter int LOG_MAX_SIZE = ntg_pkg::LOG_MAX_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [LOG_MAX_SIZE-1:0]           i_index,
    input  logic                              i_cfg_we,
    input  logic [ntg_pkg::CFG_A_W-1:0]       i_cfg_index,
    input  logic [ntg_pkg::DATA_W-1:0]        i_cfg_data,
    output logic                              o_strobe,
    output logic [ntg_pkg::DATA_W-1:0]        o_twiddle,
    output logic signed [ntg_pkg::DATA_W-1:0] o_twiddle_centered,
    output logic                              o_index_invalid
);

    localparam int IW = LOG_MAX_SIZE;
    localparam int DW = ntg_pkg::DATA_W;
    localparam int CW = $clog2(DW);

    // configuration
    logic [DW-1:0]             r_modulus;
    logic [ntg_pkg::LOG_W-1:0] r_log_size;
    logic [DW-1:0]             r_root;
    logic [DW-1:0]             r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= ntg_pkg::MODULUS_RST;
            r_log_size <= ntg_pkg::LOG_SIZE_RST;
            r_root     <= ntg_pkg::ROOT_RST;
            r_scale    <= ntg_pkg::SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ntg_pkg::REG_MODULUS:  r_modulus  <= i_cfg_data;
                ntg_pkg::REG_LOG_SIZE: r_log_size <= i_cfg_data[ntg_pkg::LOG_W-1:0];
                ntg_pkg::REG_ROOT:     r_root     <= i_cfg_data;
                ntg_pkg::REG_SCALE:    r_scale    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturated log size and derived values
    logic [ntg_pkg::LG_W-1:0] lg;
    logic [ntg_pkg::LG_W-1:0] lgm1;
    logic [DW-1:0]            one_mod;
    logic [DW:0]              q17;

    assign lg = ({1'b0, r_log_size} > ntg_pkg::LG_W'(LOG_MAX_SIZE))
              ? ntg_pkg::LG_W'(LOG_MAX_SIZE) : {1'b0, r_log_size};
    assign lgm1    = lg - ntg_pkg::LG_W'(1);
    assign one_mod = (r_modulus == DW'(1)) ? '0 : DW'(1);
    assign q17     = {1'b0, r_modulus};

    // datapath and control registers
    ntg_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_v, n_v;
    logic [IW-1:0]   r_e, n_e;
    logic [DW-1:0]   r_acc, n_acc;
    logic [DW-1:0]   r_base, n_base;
    logic [DW-1:0]   r_ma, n_ma;
    logic [DW-1:0]   r_mb, n_mb;
    logic [DW-1:0]   r_mp, n_mp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_inv, n_inv;
    logic            r_strobe, n_strobe;
    logic [DW-1:0]   r_tw, n_tw;
    logic [DW-1:0]   r_twc, n_twc;
    logic            r_oinv, n_oinv;

    // one interleaved multiply step: mp = 2*mp + bit*mb mod q
    logic [DW:0]   t1, t2, t3;
    logic [DW-1:0] mstep;

    always_comb begin
        t1    = {r_mp, 1'b0};
        t2    = (t1 >= q17) ? t1 - q17 : t1;
        t3    = t2 + (r_ma[DW-1] ? {1'b0, r_mb} : '0);
        mstep = (t3 >= q17) ? DW'(t3 - q17) : t3[DW-1:0];
    end

    logic          accept;
    logic          mul_done;
    logic [IW-1:0] v_sh;
    logic [IW-1:0] e_half;

    assign accept   = start && (r_state == ntg_pkg::ST_IDLE);
    assign mul_done = (r_cnt == CW'(DW - 1));
    assign v_sh     = r_v >> lgm1;
    assign e_half   = r_e >> 1;

    always_comb begin
        n_state  = r_state;
        n_v      = r_v;
        n_e      = r_e;
        n_acc    = r_acc;
        n_base   = r_base;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_mp     = r_mp;
        n_cnt    = r_cnt;
        n_inv    = r_inv;
        n_strobe = 1'b0;
        n_tw     = r_tw;
        n_twc    = r_twc;
        n_oinv   = r_oinv;

        case (r_state)
            ntg_pkg::ST_IDLE: begin
                if (accept) begin
                    n_acc = '0;
                    n_v   = i_index;
                    n_inv = ((i_index >> lg) != '0);
                    if (n_inv || (i_index == '0) || (r_modulus == '0)) begin
                        n_state = ntg_pkg::ST_OUT;
                    end else begin
                        n_state = ntg_pkg::ST_NORM;
                    end
                end
            end
            ntg_pkg::ST_NORM: begin
                if (v_sh[0]) begin
                    n_e     = r_v & ~(IW'(1) << lgm1);
                    n_state = ntg_pkg::ST_RED_ROOT;
                end else begin
                    n_v = r_v << 1;
                end
            end
            ntg_pkg::ST_RED_ROOT: begin
                if (mul_done) begin
                    n_base  = mstep;
                    n_state = ntg_pkg::ST_RED_SCALE;
                end
            end
            ntg_pkg::ST_RED_SCALE: begin
                if (mul_done) begin
                    n_acc = mstep;
                    if (r_e == '0) begin
                        n_state = ntg_pkg::ST_OUT;
                    end else if (r_e[0]) begin
                        n_state = ntg_pkg::ST_MUL_ACC;
                    end else begin
                        n_state = ntg_pkg::ST_MUL_SQR;
                    end
                end
            end
            ntg_pkg::ST_MUL_ACC: begin
                if (mul_done) begin
                    n_acc   = mstep;
                    n_state = (e_half == '0) ? ntg_pkg::ST_OUT : ntg_pkg::ST_MUL_SQR;
                end
            end
            ntg_pkg::ST_MUL_SQR: begin
                if (mul_done) begin
                    n_base = mstep;
                    n_e    = e_half;
                    if (e_half == '0) begin
                        n_state = ntg_pkg::ST_OUT;
                    end else if (e_half[0]) begin
                        n_state = ntg_pkg::ST_MUL_ACC;
                    end else begin
                        n_state = ntg_pkg::ST_MUL_SQR;
                    end
                end
            end
            ntg_pkg::ST_OUT: begin
                n_strobe = 1'b1;
                n_tw     = r_acc;
                n_twc    = (r_acc > (r_modulus >> 1)) ? r_acc - r_modulus : r_acc;
                n_oinv   = r_inv;
                n_state  = ntg_pkg::ST_IDLE;
            end
            default: begin
                n_state = ntg_pkg::ST_IDLE;
            end
        endcase

        // operand load for the next product, or one step of the current one
        if ((n_state != r_state) || mul_done) begin
            n_mp  = '0;
            n_cnt = '0;
            case (n_state)
                ntg_pkg::ST_RED_ROOT: begin
                    n_ma = r_root;
                    n_mb = one_mod;
                end
                ntg_pkg::ST_RED_SCALE: begin
                    n_ma = r_scale;
                    n_mb = one_mod;
                end
                ntg_pkg::ST_MUL_ACC: begin
                    n_ma = n_acc;
                    n_mb = n_base;
                end
                ntg_pkg::ST_MUL_SQR: begin
                    n_ma = n_base;
                    n_mb = n_base;
                end
                default: ;
            endcase
        end else begin
            n_mp  = mstep;
            n_ma  = r_ma << 1;
            n_cnt = r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ntg_pkg::ST_IDLE;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v    <= n_v;
        r_e    <= n_e;
        r_acc  <= n_acc;
        r_base <= n_base;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_mp   <= n_mp;
        r_inv  <= n_inv;
        r_tw   <= n_tw;
        r_twc  <= n_twc;
        r_oinv <= n_oinv;
    end

    assign busy               = (r_state != ntg_pkg::ST_IDLE);
    assign o_strobe           = r_strobe;
    assign o_twiddle          = r_tw;
    assign o_twiddle_centered = signed'(r_twc);
    assign o_index_invalid    = r_oinv;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NTT twiddle generator. Register settings and
// table indexes are driven through the config and command ports. Each
// accepted index is run through a local closed-form twiddle calculation, and
// every strobed result is compared field by field against the oldest pending
// entry. Directed corner cases come first, then randomized phases with random
// register settings and bursty command traffic.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LOG_MAX = ntg_pkg::LOG_MAX_SIZE_DEF;
    localparam int IDX_W   = ntg_pkg::LOG_MAX_SIZE_DEF;
    localparam int DATA_W  = ntg_pkg::DATA_W;
    localparam int CFG_A_W = ntg_pkg::CFG_A_W;
    localparam int LOG_W   = ntg_pkg::LOG_W;

    typedef struct packed {
        logic [DATA_W-1:0] twiddle;
        logic [DATA_W-1:0] centered;
        logic              invalid;
    } t_twiddle;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [IDX_W-1:0]         i_index;
    logic                     i_cfg_we;
    logic [CFG_A_W-1:0]       i_cfg_index;
    logic [DATA_W-1:0]        i_cfg_data;
    logic                     o_strobe;
    logic [DATA_W-1:0]        o_twiddle;
    logic signed [DATA_W-1:0] o_twiddle_centered;
    logic                     o_index_invalid;

    // register shadow
    logic [DATA_W-1:0] cfg_modulus;
    logic [LOG_W-1:0]  cfg_log_size;
    logic [DATA_W-1:0] cfg_root;
    logic [DATA_W-1:0] cfg_scale;

    t_twiddle pending_twiddles[$];
    int       mismatch_count;
    int       burst_left;
    bit       idle_enable;

    ntt_twiddle_generator #(
        .LOG_MAX_SIZE(ntg_pkg::LOG_MAX_SIZE_DEF)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_index            (i_index),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_strobe           (o_strobe),
        .o_twiddle          (o_twiddle),
        .o_twiddle_centered (o_twiddle_centered),
        .o_index_invalid    (o_index_invalid)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_twiddle predict_twiddle(input logic [IDX_W-1:0] idx);
        t_twiddle          r;
        int                lg;
        int                n;
        int                msb;
        logic [IDX_W-1:0]  j;
        longint unsigned   q;
        longint unsigned   e;
        longint unsigned   acc;
        longint unsigned   b;
        longint unsigned   x;
        r   = '0;
        lg  = (int'(cfg_log_size) > LOG_MAX) ? LOG_MAX : int'(cfg_log_size);
        n   = 1 << lg;
        q   = longint'(cfg_modulus);
        if (int'(idx) >= n) begin
            r.invalid = 1'b1;
        end else if (idx != '0 && q != 0) begin
            msb = 0;
            for (int k = 0; k < IDX_W; k++)
                if (idx[k]) msb = k;
            j   = idx - (IDX_W'(1) << msb);
            e   = longint'(j) << (lg - 1 - msb);
            acc = 1 % q;
            b   = longint'(cfg_root) % q;
            while (e != 0) begin
                if (e[0]) acc = (acc * b) % q;
                e = e >> 1;
                b = (b * b) % q;
            end
            x = ((longint'(cfg_scale) % q) * acc) % q;
            r.twiddle  = x[DATA_W-1:0];
            if (x > q / 2)
                r.centered = DATA_W'(x - q);
            else
                r.centered = x[DATA_W-1:0];
        end
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_twiddle exp_tw;
        if (i_rst_n && o_strobe) begin
            if (pending_twiddles.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result tw=%0d ctr=%0d inv=%0b",
                             o_twiddle, o_twiddle_centered, o_index_invalid);
            end else begin
                exp_tw = pending_twiddles.pop_front();
                if (o_twiddle !== exp_tw.twiddle || o_twiddle_centered !== exp_tw.centered
                    || o_index_invalid !== exp_tw.invalid) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: exp tw=%0d ctr=%0d inv=%0b got tw=%0d ctr=%0d inv=%0b",
                                 exp_tw.twiddle, $signed(exp_tw.centered), exp_tw.invalid,
                                 o_twiddle, o_twiddle_centered, o_index_invalid);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = addr;
        i_cfg_data  = data;
        @(posedge i_clk);
        case (addr)
            ntg_pkg::REG_MODULUS:  cfg_modulus  = data;
            ntg_pkg::REG_LOG_SIZE: cfg_log_size = data[LOG_W-1:0];
            ntg_pkg::REG_ROOT:     cfg_root     = data;
            ntg_pkg::REG_SCALE:    cfg_scale    = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] lg,
                              input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] s);
        write_reg(ntg_pkg::REG_MODULUS, q);
        write_reg(ntg_pkg::REG_LOG_SIZE, lg);
        write_reg(ntg_pkg::REG_ROOT, w);
        write_reg(ntg_pkg::REG_SCALE, s);
    endtask

    // one command transfer; start stays high into the next call when no gap follows
    task automatic send_index(input logic [IDX_W-1:0] idx);
        int gap;
        @(negedge i_clk);
        start   = 1'b1;
        i_index = idx;
        do @(posedge i_clk); while (busy);
        pending_twiddles.push_back(predict_twiddle(idx));
        gap = 0;
        if (idle_enable) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 350)
                                                   : $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
        if (gap > 0) begin
            @(negedge i_clk);
            start   = 1'b0;
            i_index = IDX_W'($urandom_range(0, 1023));
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain;
        @(negedge i_clk);
        start = 1'b0;
        while (pending_twiddles.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults;
        send_index('0);
        send_index(IDX_W'(1));
        send_index(IDX_W'(511));
        send_index(IDX_W'(512));
        send_index(IDX_W'(1023));
        drain();
    endtask

    task automatic test_full_table;
        set_config(16'd12289, 16'd10, 16'd10302, 16'd8974);
        send_index('0);
        send_index(IDX_W'(1));
        send_index(IDX_W'(2));
        send_index(IDX_W'(3));
        send_index(IDX_W'(512));
        send_index(IDX_W'(767));
        send_index(IDX_W'(1023));
        send_index(IDX_W'(10'h2AA));
        send_index(IDX_W'(10'h155));
        drain();
    endtask

    task automatic test_corner_configs;
        // zero modulus: entry forced to zero, invalid flag still reported
        set_config(16'd0, 16'd8, 16'd3, 16'd5);
        send_index(IDX_W'(37));
        send_index(IDX_W'(300));
        drain();
        set_config(16'd1, 16'd10, 16'd7, 16'd9);
        send_index(IDX_W'(777));
        drain();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF);
        send_index(IDX_W'(1000));
        send_index(IDX_W'(513));
        drain();
        // log size zero: only index zero is valid
        set_config(16'd2, 16'd0, 16'd1, 16'd1);
        send_index('0);
        send_index(IDX_W'(1));
        drain();
        set_config(16'd65521, 16'd1, 16'd65520, 16'd65533);
        send_index(IDX_W'(1));
        send_index(IDX_W'(2));
        drain();
    endtask

    task automatic test_random_phases;
        logic [DATA_W-1:0] q;
        logic [DATA_W-1:0] lg;
        int                n;
        int                lgv;
        int                items;
        logic [IDX_W-1:0]  idx;
        for (int ph = 0; ph < 35; ph++) begin
            case ($urandom_range(0, 11))
                0:       q = 16'd12289;
                1:       q = 16'd7681;
                2:       q = 16'd3329;
                3:       q = 16'd65521;
                4:       q = 16'd257;
                5:       q = 16'd40961;
                6:       q = 16'($urandom_range(0, 2));
                7:       q = 16'hFFFF;
                default: q = 16'($urandom_range(3, 65535));
            endcase
            lgv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 10);
            lg  = {12'($urandom_range(0, 4095)), 4'(lgv)};
            if ($urandom_range(0, 1)) lg[DATA_W-1:LOG_W] = '0;
            set_config(q, lg, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            idle_enable = ($urandom_range(0, 4) != 0);
            burst_left  = 0;
            lgv   = (lgv > LOG_MAX) ? LOG_MAX : lgv;
            n     = 1 << lgv;
            items = $urandom_range(40, 60);
            for (int k = 0; k < items; k++) begin
                case ($urandom_range(0, 9))
                    0:       idx = '0;
                    1:       idx = IDX_W'($urandom_range(0, 1023));
                    default: idx = (n > 1) ? IDX_W'($urandom_range(1, n - 1))
                                           : IDX_W'($urandom_range(0, 1023));
                endcase
                send_index(idx);
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_index      = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        cfg_modulus  = ntg_pkg::MODULUS_RST;
        cfg_log_size = ntg_pkg::LOG_SIZE_RST;
        cfg_root     = ntg_pkg::ROOT_RST;
        cfg_scale    = ntg_pkg::SCALE_RST;
        mismatch_count = 0;
        burst_left   = 0;
        idle_enable  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        test_reset_defaults();
        idle_enable = 1'b1;
        test_full_table();
        test_corner_configs();
        test_random_phases();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_twiddles.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
